// ===== src/rmae_pkg.sv =====
// ----------------------------------------------------------------------------
// rmae_pkg
// Shared codes and controller/datapath interface types of the executor.
// ----------------------------------------------------------------------------
package rmae_pkg;

  localparam int ACT_W    = 3;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int IDX_W    = 5;
  localparam int IMM_W    = 31;
  localparam int OUT_W    = 32;

  localparam logic [ACT_W-1:0] ACT_MOV = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADD = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SUB = 3'd2;
  localparam logic [ACT_W-1:0] ACT_MUL = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DIV = 3'd4;

  localparam logic [KIND_W-1:0] SRC_IMM = 2'd0;
  localparam logic [KIND_W-1:0] SRC_REG = 2'd1;
  localparam logic [KIND_W-1:0] SRC_MEM = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DIV0    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ILLEGAL = 2'd2;

  typedef struct packed {
    logic load;
    logic rd_dst;
    logic rd_src;
    logic cap_src;
    logic exec;
    logic step;
    logic commit;
    logic clear;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_iter;
    logic iter_last;
    logic out_busy;
  } ctl_stat_t;

endpackage

// ===== src/rmae_ram.sv =====
// ----------------------------------------------------------------------------
// rmae_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/rmae_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmae_ctrl
// Sequencer: memory clear, operand reads, execute, iterate, write back.
// ----------------------------------------------------------------------------
module rmae_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rmae_pkg::ctl_stat_t  stat,
  output rmae_pkg::ctl_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_DST,
    S_RD_SRC,
    S_CAP,
    S_EXEC,
    S_ITER,
    S_WB
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && !in_stall_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD_DST;
        end
      end
      S_RD_DST: begin
        cmd.rd_dst = 1'b1;
        state_nxt  = S_RD_SRC;
      end
      S_RD_SRC: begin
        cmd.rd_src = 1'b1;
        state_nxt  = S_CAP;
      end
      S_CAP: begin
        cmd.cap_src = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.need_iter ? S_ITER : S_WB;
      end
      S_ITER: begin
        cmd.step = 1'b1;
        if (stat.iter_last) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = in_stall_r;

  a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !cmd.load && in_stall)
    else $error("transaction accepted while previous one in flight");

endmodule

// ===== src/rmae_dp.sv =====
// ----------------------------------------------------------------------------
// rmae_dp
// Datapath: register file, data memory, shift-add multiplier, restoring
// divider and result register.
// ----------------------------------------------------------------------------
module rmae_dp #(
  parameter int MEM_WORDS  = 32,
  parameter int NUM_REGS   = 6,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rmae_pkg::ctl_cmd_t                  cmd,
  output rmae_pkg::ctl_stat_t                 stat,
  input  logic [rmae_pkg::ACT_W-1:0]          in_action,
  input  logic                                in_dest_is_memory,
  input  logic [rmae_pkg::IDX_W-1:0]          in_dest_index,
  input  logic [rmae_pkg::KIND_W-1:0]         in_source_kind,
  input  logic [rmae_pkg::IDX_W-1:0]          in_source_index,
  input  logic [rmae_pkg::IMM_W-1:0]          in_immediate_value,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [rmae_pkg::STATUS_W-1:0]       out_status,
  output logic [rmae_pkg::OUT_W-1:0]          out_value
);

  localparam int MEM_AW = $clog2(MEM_WORDS);
  localparam int REG_AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CNT_W  = $clog2(DATA_WIDTH);
  localparam int W      = DATA_WIDTH;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (~v + W'(1)) : v;
  endfunction

  logic [rmae_pkg::ACT_W-1:0]    action_r;
  logic                          dmem_r;
  logic [rmae_pkg::IDX_W-1:0]    didx_r;
  logic [rmae_pkg::KIND_W-1:0]   kind_r;
  logic [rmae_pkg::IDX_W-1:0]    sidx_r;
  logic [rmae_pkg::IMM_W-1:0]    imm_r;
  logic                          dst_ok_r;
  logic                          illegal_r;
  logic                          dst_ok;
  logic                          src_ok;
  logic                          illegal;

  logic [W-1:0]                  regs_r [NUM_REGS];
  logic [W-1:0]                  reg_rdata_r;
  logic [rmae_pkg::IDX_W-1:0]    rd_idx;
  logic [W-1:0]                  ram_rdata;
  logic                          ram_we;
  logic [MEM_AW-1:0]             ram_waddr;
  logic [W-1:0]                  ram_wdata;
  logic [MEM_AW-1:0]             clr_ptr_r;

  logic [W-1:0]                  old_r;
  logic [W-1:0]                  src_r;
  logic [W-1:0]                  res_r;
  logic [rmae_pkg::STATUS_W-1:0] status_r;

  logic [W-1:0]                  acc_r;
  logic [W-1:0]                  mcand_r;
  logic [W-1:0]                  mplr_r;
  logic [W:0]                    rem_r;
  logic [W-1:0]                  quo_r;
  logic [W-1:0]                  dvs_r;
  logic                          neg_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [W:0]                    rem_shift;
  logic [W+1:0]                  rem_diff;

  logic [W-1:0]                  calc_val;
  logic [W-1:0]                  final_val;
  logic                          write_ok;

  logic                          out_valid_r;
  logic [rmae_pkg::STATUS_W-1:0] out_status_r;
  logic [rmae_pkg::OUT_W-1:0]    out_value_r;

  always_comb begin
    dst_ok = in_dest_is_memory ? (32'(in_dest_index) < MEM_WORDS)
                               : (32'(in_dest_index) < NUM_REGS);
    unique case (in_source_kind)
      rmae_pkg::SRC_IMM: src_ok = 1'b1;
      rmae_pkg::SRC_REG: src_ok = (32'(in_source_index) < NUM_REGS);
      rmae_pkg::SRC_MEM: src_ok = !in_dest_is_memory && (32'(in_source_index) < MEM_WORDS);
      default:           src_ok = 1'b0;
    endcase
    illegal = (in_action > rmae_pkg::ACT_DIV) || !dst_ok || !src_ok;
  end

  assign rd_idx    = cmd.rd_dst ? didx_r : sidx_r;
  assign rem_shift = {rem_r[W-1:0], quo_r[W-1]};
  assign rem_diff  = {1'b0, rem_shift} - {2'b00, dvs_r};

  always_comb begin
    unique case (action_r)
      rmae_pkg::ACT_MUL: calc_val = acc_r;
      rmae_pkg::ACT_DIV: calc_val = neg_r ? (~quo_r + W'(1)) : quo_r;
      default:           calc_val = res_r;
    endcase
    write_ok  = (status_r == rmae_pkg::ST_DONE);
    final_val = write_ok ? calc_val : old_r;
  end

  assign ram_we    = cmd.clear || (cmd.commit && write_ok && dmem_r);
  assign ram_waddr = cmd.clear ? clr_ptr_r : MEM_AW'(didx_r);
  assign ram_wdata = cmd.clear ? '0 : calc_val;

  rmae_ram #(
    .WIDTH (W),
    .DEPTH (MEM_WORDS)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (MEM_AW'(rd_idx)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r  <= in_action;
      dmem_r    <= in_dest_is_memory;
      didx_r    <= in_dest_index;
      kind_r    <= in_source_kind;
      sidx_r    <= in_source_index;
      imm_r     <= in_immediate_value;
      dst_ok_r  <= dst_ok;
      illegal_r <= illegal;
    end
    if (cmd.rd_dst || cmd.rd_src) begin
      reg_rdata_r <= (32'(rd_idx) < NUM_REGS) ? regs_r[REG_AW'(rd_idx)] : '0;
    end
    if (cmd.rd_src) begin
      old_r <= !dst_ok_r ? '0 : (dmem_r ? ram_rdata : reg_rdata_r);
    end
    if (cmd.cap_src) begin
      unique case (kind_r)
        rmae_pkg::SRC_IMM: src_r <= W'(imm_r);
        rmae_pkg::SRC_REG: src_r <= reg_rdata_r;
        rmae_pkg::SRC_MEM: src_r <= ram_rdata;
        default:           src_r <= '0;
      endcase
    end
    if (cmd.exec) begin
      priority if (illegal_r) begin
        status_r <= rmae_pkg::ST_ILLEGAL;
      end else if (action_r == rmae_pkg::ACT_DIV && src_r == '0) begin
        status_r <= rmae_pkg::ST_DIV0;
      end else begin
        status_r <= rmae_pkg::ST_DONE;
      end
      unique case (action_r)
        rmae_pkg::ACT_ADD: res_r <= old_r + src_r;
        rmae_pkg::ACT_SUB: res_r <= old_r - src_r;
        default:           res_r <= src_r;
      endcase
      acc_r   <= '0;
      mcand_r <= old_r;
      mplr_r  <= src_r;
      rem_r   <= '0;
      quo_r   <= mag(old_r);
      dvs_r   <= mag(src_r);
      neg_r   <= old_r[W-1] ^ src_r[W-1];
      cnt_r   <= '0;
    end
    if (cmd.step) begin
      if (mplr_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r <= mcand_r << 1;
      mplr_r  <= mplr_r >> 1;
      if (!rem_diff[W+1]) begin
        rem_r <= rem_diff[W:0];
        quo_r <= {quo_r[W-2:0], 1'b1};
      end else begin
        rem_r <= rem_shift;
        quo_r <= {quo_r[W-2:0], 1'b0};
      end
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.commit) begin
      out_status_r <= status_r;
      out_value_r  <= rmae_pkg::OUT_W'(final_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      clr_ptr_r   <= '0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.clear) begin
        clr_ptr_r <= clr_ptr_r + MEM_AW'(1);
      end
      if (cmd.commit && write_ok && !dmem_r) begin
        regs_r[REG_AW'(didx_r)] <= calc_val;
      end
    end
  end

  always_comb begin
    stat.clear_last = (clr_ptr_r == MEM_AW'(MEM_WORDS - 1));
    stat.need_iter  = !illegal_r &&
                      (action_r == rmae_pkg::ACT_MUL ||
                       (action_r == rmae_pkg::ACT_DIV && src_r != '0));
    stat.iter_last  = (cnt_r == CNT_W'(W - 1));
    stat.out_busy   = out_valid_r && out_stall;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

  a_rise_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit))
    else $error("result valid without commit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && out_stall))
    else $error("pending result overwritten");

  a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clear && (cmd.commit || cmd.load)))
    else $error("transaction activity during memory clear");

  a_div0_only_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && status_r == rmae_pkg::ST_DIV0) |-> (action_r == rmae_pkg::ACT_DIV))
    else $error("divide-by-zero status on non-divide");

endmodule

// ===== src/register_memory_alu_executor.sv =====
// ----------------------------------------------------------------------------
// register_memory_alu_executor
// Executes one decoded two-operand instruction (move, add, subtract,
// multiply, signed divide) on a register file and a data memory.
// Input channel in_*: one instruction per transaction; result channel out_*:
//   one status and written value per transaction. Both transfer when valid
//   is high and stall is low.
// Sequence: each instruction passes the destination read, source read,
//   capture, execute and write-back states before out_valid rises; a legal
//   multiply or nonzero divide also iterates between execute and write
//   back in the one-bit-per-cycle shift-add multiplier and restoring
//   divider. One instruction is in work at a time and the next is taken
//   the cycle after write back.
// Reset: registers clear at once; the data memory is then cleared one
//   word per cycle, all MEM_WORDS words, with in_stall held high.
// Receiver stall: the result waits in the output register; a following
//   instruction still executes but holds at write back until the pending
//   result is taken.
// ----------------------------------------------------------------------------
module register_memory_alu_executor #(
  parameter int MEM_WORDS  = 32,
  parameter int NUM_REGS   = 6,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rmae_pkg::ACT_W-1:0]          in_action,
  input  logic                                in_dest_is_memory,
  input  logic [rmae_pkg::IDX_W-1:0]          in_dest_index,
  input  logic [rmae_pkg::KIND_W-1:0]         in_source_kind,
  input  logic [rmae_pkg::IDX_W-1:0]          in_source_index,
  input  logic [rmae_pkg::IMM_W-1:0]          in_immediate_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rmae_pkg::STATUS_W-1:0]       out_status,
  output logic signed [rmae_pkg::OUT_W-1:0]   out_written_value
);

  rmae_pkg::ctl_cmd_t         cmd;
  rmae_pkg::ctl_stat_t        stat;
  logic [rmae_pkg::OUT_W-1:0] value;

  rmae_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rmae_dp #(
    .MEM_WORDS  (MEM_WORDS),
    .NUM_REGS   (NUM_REGS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_action          (in_action),
    .in_dest_is_memory  (in_dest_is_memory),
    .in_dest_index      (in_dest_index),
    .in_source_kind     (in_source_kind),
    .in_source_index    (in_source_index),
    .in_immediate_value (in_immediate_value),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_value          (value)
  );

  assign out_written_value = value;

endmodule
